// ===== design/hlpc_pkg.sv =====
// Shared constants, command/status types for the HSV lamp PWM controller.
`timescale 1ns / 1ps

package hlpc_pkg;

    localparam int OP_W      = 2;
    localparam int HUE_W     = 9;
    localparam int PCT_W     = 7;
    localparam int X_W       = 13;
    localparam int P_W       = 20;
    localparam int N_W       = 24;
    localparam int LVL_W     = 8;
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 48;
    localparam int M_TUSER_W = 2;
    localparam int NUM_LANES = 3;

    localparam logic [OP_W-1:0] OP_SET_POWER  = 2'd0;
    localparam logic [OP_W-1:0] OP_SET_COLOR  = 2'd1;
    localparam logic [OP_W-1:0] OP_SET_BRIGHT = 2'd2;
    localparam logic [OP_W-1:0] OP_WAKE       = 2'd3;

    localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;
    localparam logic [HUE_W-1:0] HUE_WRAP = 9'd360;
    localparam logic [X_W-1:0]   X_FULL   = 13'd6000;
    // level = floor(17*v*X / 40000), quotient by reciprocal with one correction
    localparam logic [16:0]      RECIP    = 17'd107375;
    localparam logic [15:0]      DIV_C    = 16'd40000;

    typedef struct packed {
        logic accept;
        logic mix;
        logic mul;
        logic div;
        logic fix;
        logic lvl;
        logic load_out;
    } hlpc_cmd_t;

    typedef struct packed {
        logic no_result;
    } hlpc_status_t;

endpackage

// ===== design/hlpc_ctrl.sv =====
// Controller FSM: sequences the conversion stages and owns the result valid.
`timescale 1ns / 1ps

module hlpc_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    input  hlpc_pkg::hlpc_status_t status,
    output hlpc_pkg::hlpc_cmd_t    cmd
);
    import hlpc_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MIX  = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_FIX  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;
    localparam logic [2:0] ST_LVL  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;

    always_comb begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.accept   = (state_reg == ST_IDLE) && s_tvalid;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && !status.no_result) begin
                    state_next = ST_MIX;
                end
            end
            ST_MIX: begin
                cmd.mix    = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.div    = 1'b1;
                state_next = ST_FIX;
            end
            ST_FIX: begin
                cmd.fix    = 1'b1;
                state_next = ST_LVL;
            end
            ST_LVL: begin
                cmd.lvl    = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== design/hlpc_datapath.sv =====
// Datapath: lamp state, three-lane HSV-to-duty conversion, result register.
`timescale 1ns / 1ps

module hlpc_datapath (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  hlpc_pkg::hlpc_cmd_t                cmd,
    output hlpc_pkg::hlpc_status_t             status,
    input  logic [hlpc_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [hlpc_pkg::S_TUSER_W-1:0]    s_tuser,
    output logic [hlpc_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic [hlpc_pkg::M_TUSER_W-1:0]    m_tuser
);
    import hlpc_pkg::*;

    localparam logic [1:0] SEL_MAX = 2'd0;
    localparam logic [1:0] SEL_MIN = 2'd1;
    localparam logic [1:0] SEL_UP  = 2'd2;
    localparam logic [1:0] SEL_DN  = 2'd3;

    // request fields
    logic [OP_W-1:0]  in_op;
    logic             in_power;
    logic [HUE_W-1:0] in_hue;
    logic [PCT_W-1:0] in_sat, in_val;

    assign in_op    = s_tuser;
    assign in_power = s_tdata[0];
    assign in_hue   = s_tdata[9:1];
    assign in_sat   = (s_tdata[16:10] > PCT_FULL) ? PCT_FULL : s_tdata[16:10];
    assign in_val   = (s_tdata[23:17] > PCT_FULL) ? PCT_FULL : s_tdata[23:17];

    logic             power_reg;
    logic [HUE_W-1:0] hue_reg;
    logic [PCT_W-1:0] sat_reg, val_reg;
    logic             drive_off_reg, report_reg;

    assign status.no_result = (in_op == OP_WAKE) && !power_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            power_reg <= 1'b0;
            hue_reg   <= '0;
            sat_reg   <= '0;
            val_reg   <= '0;
        end else if (cmd.accept) begin
            case (in_op)
                OP_SET_POWER: begin
                    power_reg <= in_power;
                end
                OP_SET_COLOR: begin
                    power_reg <= 1'b1;
                    hue_reg   <= in_hue;
                    sat_reg   <= in_sat;
                    val_reg   <= in_val;
                end
                OP_SET_BRIGHT: begin
                    power_reg <= 1'b1;
                    val_reg   <= in_val;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            drive_off_reg <= (in_op == OP_SET_POWER) && !in_power;
            report_reg    <= (in_op != OP_WAKE);
        end
    end

    // sector split of the hue
    logic [HUE_W-1:0] hue_eff;
    logic [2:0]       sector;
    logic [HUE_W-1:0] sector_base;
    logic [5:0]       frac;
    logic [X_W-1:0]   sf, xmin, xup, xdn;
    logic [5:0]       sel_all;

    always_comb begin
        hue_eff = (hue_reg >= HUE_WRAP) ? '0 : hue_reg;
        if (hue_eff < 9'd60) begin
            sector = 3'd0;
        end else if (hue_eff < 9'd120) begin
            sector = 3'd1;
        end else if (hue_eff < 9'd180) begin
            sector = 3'd2;
        end else if (hue_eff < 9'd240) begin
            sector = 3'd3;
        end else if (hue_eff < 9'd300) begin
            sector = 3'd4;
        end else begin
            sector = 3'd5;
        end
        sector_base = {6'b0, sector} * 9'd60;
        frac        = 6'(hue_eff - sector_base);
        sf          = X_W'(sat_reg) * X_W'(frac);
        xmin        = X_W'(PCT_FULL - sat_reg) * 13'd60;
        xup         = xmin + sf;
        xdn         = X_FULL - sf;
        // {red, green, blue} selections
        case (sector)
            3'd0:    sel_all = {SEL_MAX, SEL_UP,  SEL_MIN};
            3'd1:    sel_all = {SEL_DN,  SEL_MAX, SEL_MIN};
            3'd2:    sel_all = {SEL_MIN, SEL_MAX, SEL_UP};
            3'd3:    sel_all = {SEL_MIN, SEL_DN,  SEL_MAX};
            3'd4:    sel_all = {SEL_UP,  SEL_MIN, SEL_MAX};
            default: sel_all = {SEL_MAX, SEL_MIN, SEL_DN};
        endcase
    end

    // lane 0 red, 1 green, 2 blue
    logic [X_W-1:0]   x_reg   [NUM_LANES];
    logic [P_W-1:0]   p_reg   [NUM_LANES];
    logic [N_W-1:0]   n_reg   [NUM_LANES];
    logic [HUE_W-1:0] q_reg   [NUM_LANES];
    logic [LVL_W-1:0] lvl_reg [NUM_LANES];
    logic [PCT_W-1:0] duty    [NUM_LANES];

    logic [1:0]       sel     [NUM_LANES];
    logic [N_W-1:0]   n_val   [NUM_LANES];
    logic [40:0]      prod    [NUM_LANES];
    logic [24:0]      back    [NUM_LANES];
    logic [14:0]      scaled  [NUM_LANES];
    logic [15:0]      tmp     [NUM_LANES];
    logic [PCT_W-1:0] pct     [NUM_LANES];

    assign sel[0] = sel_all[5:4];
    assign sel[1] = sel_all[3:2];
    assign sel[2] = sel_all[1:0];

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            n_val[i]  = {p_reg[i], 4'b0} + N_W'(p_reg[i]);
            prod[i]   = 41'(n_reg[i]) * 41'(RECIP);
            back[i]   = 25'(q_reg[i]) * 25'(DIV_C);
            scaled[i] = 15'(lvl_reg[i]) * 15'd100;
            tmp[i]    = 16'(scaled[i]) + 16'd1 + 16'(scaled[i][14:8]);
            pct[i]    = tmp[i][14:8];
            duty[i]   = drive_off_reg ? PCT_FULL : (PCT_FULL - pct[i]);
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_LANES; i++) begin
            if (cmd.mix) begin
                case (sel[i])
                    SEL_MAX: x_reg[i] <= X_FULL;
                    SEL_MIN: x_reg[i] <= xmin;
                    SEL_UP:  x_reg[i] <= xup;
                    default: x_reg[i] <= xdn;
                endcase
            end
            if (cmd.mul) begin
                p_reg[i] <= P_W'(val_reg) * P_W'(x_reg[i]);
            end
            if (cmd.div) begin
                n_reg[i] <= n_val[i];
            end
            if (cmd.fix) begin
                q_reg[i] <= prod[i][40:32];
            end
        end
    end

    // correction stage: lvl from q and n
    logic [HUE_W-1:0] lvl_fix [NUM_LANES];

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            lvl_fix[i] = (back[i] > 25'(n_reg[i])) ? (q_reg[i] - 9'd1) : q_reg[i];
        end
    end

    // result register
    logic [PCT_W-1:0] out_duty_reg [NUM_LANES];
    logic             out_rep_reg, out_pow_reg;
    logic [HUE_W-1:0] out_hue_reg;
    logic [PCT_W-1:0] out_sat_reg, out_val_reg;

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NUM_LANES; i++) begin
            if (cmd.lvl) begin
                lvl_reg[i] <= lvl_fix[i][LVL_W-1:0];
            end
            if (cmd.load_out) begin
                out_duty_reg[i] <= duty[i];
            end
        end
        if (cmd.load_out) begin
            out_rep_reg <= report_reg;
            out_pow_reg <= report_reg & power_reg;
            out_hue_reg <= report_reg ? hue_reg : '0;
            out_sat_reg <= report_reg ? sat_reg : '0;
            out_val_reg <= report_reg ? val_reg : '0;
        end
    end

    assign m_tdata = {3'b0, out_val_reg, out_sat_reg, out_hue_reg, out_pow_reg,
                      out_duty_reg[2], out_duty_reg[1], out_duty_reg[0]};
    assign m_tuser = {out_rep_reg, 1'b1};

endmodule

// ===== design/hsv_lamp_pwm_controller_unit.sv =====
// Top level of the HSV lamp PWM controller: controller plus datapath.
//
//  channel  dir  handshake             payload
//  s_       in   s_tvalid / s_tready   s_tdata (power, hue, sat, value), s_tuser (operation)
//  m_       out  m_tvalid / m_tready   m_tdata (duties, report fields), m_tuser (valid flags)
//
// A request that yields a result reaches m_tvalid through mix, multiply, scale by 17,
// reciprocal quotient, correction, and the duty stage into the result register.
// The three color lanes run in parallel; no request is taken until the last is loaded.
// A wake-up while off is taken without leaving idle and gives no result.
// aresetn (synchronous) turns the lamp off and clears the stored color.
// A request is taken while a result still waits; the duty stage holds while that is so.
`timescale 1ns / 1ps

module hsv_lamp_pwm_controller_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // [0] power_on, [9:1] hue_in, [16:10] saturation_in, [23:17] value_in
    input  logic [hlpc_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] operation
    input  logic [hlpc_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // [6:0] duty_red_pin, [13:7] duty_green_pin, [20:14] duty_blue_pin,
    // [21] report_power, [30:22] report_hue, [37:31] report_saturation,
    // [44:38] report_value
    output logic [hlpc_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] drive_valid, [1] report_valid
    output logic [hlpc_pkg::M_TUSER_W-1:0] m_tuser
);
    import hlpc_pkg::*;

    hlpc_cmd_t    cmd;
    hlpc_status_t status;

    hlpc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hlpc_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

endmodule

// ===== verif/hlpc_drive_checker.sv =====
// Checker for the HSV lamp PWM controller: predicts duty and report fields and compares each result.
`timescale 1ns / 1ps

module hlpc_drive_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [hlpc_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic [hlpc_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [hlpc_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic [hlpc_pkg::M_TUSER_W-1:0] m_tuser,
    output int                             pending,
    output int                             errors,
    output int                             results
);
    import hlpc_pkg::*;

    typedef struct packed {
        logic             drive;
        logic [PCT_W-1:0] red;
        logic [PCT_W-1:0] green;
        logic [PCT_W-1:0] blue;
        logic             report;
        logic             power;
        logic [HUE_W-1:0] hue;
        logic [PCT_W-1:0] sat;
        logic [PCT_W-1:0] val;
    } lamp_out_t;

    lamp_out_t        expected_drives[$];
    logic             lamp_on = 1'b0;
    logic [HUE_W-1:0] hue_q   = '0;
    logic [PCT_W-1:0] sat_q   = '0;
    logic [PCT_W-1:0] val_q   = '0;
    int               err_cnt = 0;
    int               res_cnt = 0;

    function automatic logic [PCT_W-1:0] clip_pct(input logic [PCT_W-1:0] x);
        return (x > PCT_FULL) ? PCT_FULL : x;
    endfunction

    // level over common denominator 600000, then scaled to percent, active low
    function automatic logic [PCT_W-1:0] pin_duty(input int unsigned num);
        int unsigned      level;
        logic [PCT_W-1:0] d;
        level = num / 600000;
        d = PCT_W'(100 - level * 100 / 255);
        return d;
    endfunction

    function automatic lamp_out_t color_drive(input logic [HUE_W-1:0] h_in,
                                              input logic [PCT_W-1:0] s_in,
                                              input logic [PCT_W-1:0] v_in);
        int unsigned h, s, v, frac, top_lvl, low_lvl, ramp, r, g, b;
        lamp_out_t   o;
        h = (h_in >= HUE_WRAP) ? 0 : 32'(h_in);
        s = 32'(s_in);
        v = 32'(v_in);
        frac = h % 60;
        top_lvl = 1530000 * v;
        low_lvl = 15300 * v * (100 - s);
        ramp = 255 * v * s * frac;
        case (h / 60)
            0: begin r = top_lvl;        g = low_lvl + ramp; b = low_lvl;        end
            1: begin r = top_lvl - ramp; g = top_lvl;        b = low_lvl;        end
            2: begin r = low_lvl;        g = top_lvl;        b = low_lvl + ramp; end
            3: begin r = low_lvl;        g = top_lvl - ramp; b = top_lvl;        end
            4: begin r = low_lvl + ramp; g = low_lvl;        b = top_lvl;        end
            default: begin
                r = top_lvl;
                g = low_lvl;
                b = top_lvl - ramp;
            end
        endcase
        o = '0;
        o.drive = 1'b1;
        o.red = pin_duty(r);
        o.green = pin_duty(g);
        o.blue = pin_duty(b);
        return o;
    endfunction

    task automatic predict_lamp_command(input logic [OP_W-1:0] op, input logic pwr,
                                        input logic [HUE_W-1:0] hue,
                                        input logic [PCT_W-1:0] sat,
                                        input logic [PCT_W-1:0] val);
        lamp_out_t o;
        logic      gives;
        o = '0;
        gives = 1'b1;
        case (op)
            OP_SET_POWER: begin
                lamp_on = pwr;
                if (pwr) begin
                    o = color_drive(hue_q, sat_q, val_q);
                end else begin
                    o.drive = 1'b1;
                    o.red = PCT_FULL;
                    o.green = PCT_FULL;
                    o.blue = PCT_FULL;
                end
            end
            OP_SET_COLOR: begin
                lamp_on = 1'b1;
                hue_q = hue;
                sat_q = clip_pct(sat);
                val_q = clip_pct(val);
                o = color_drive(hue_q, sat_q, val_q);
            end
            OP_SET_BRIGHT: begin
                lamp_on = 1'b1;
                val_q = clip_pct(val);
                o = color_drive(hue_q, sat_q, val_q);
            end
            default: begin
                gives = lamp_on;
                if (lamp_on) o = color_drive(hue_q, sat_q, val_q);
            end
        endcase
        if (op != OP_WAKE) begin
            o.report = 1'b1;
            o.power = lamp_on;
            o.hue = hue_q;
            o.sat = sat_q;
            o.val = val_q;
        end
        if (gives) expected_drives.push_back(o);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            err_cnt++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        lamp_out_t got;
        lamp_out_t want;
        if (!aresetn) begin
            lamp_on = 1'b0;
            hue_q = '0;
            sat_q = '0;
            val_q = '0;
            expected_drives.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser[0], m_tdata[6:0], m_tdata[13:7], m_tdata[20:14], m_tuser[1],
                       m_tdata[21], m_tdata[30:22], m_tdata[37:31], m_tdata[44:38]};
                res_cnt++;
                if (expected_drives.size() == 0) begin
                    err_cnt++;
                    $display("%0t: result expected none, got m_tuser %b m_tdata %h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = expected_drives.pop_front();
                    check_field("drive_valid", 32'(want.drive), 32'(got.drive));
                    check_field("duty_red_pin", 32'(want.red), 32'(got.red));
                    check_field("duty_green_pin", 32'(want.green), 32'(got.green));
                    check_field("duty_blue_pin", 32'(want.blue), 32'(got.blue));
                    check_field("report_valid", 32'(want.report), 32'(got.report));
                    check_field("report_power", 32'(want.power), 32'(got.power));
                    check_field("report_hue", 32'(want.hue), 32'(got.hue));
                    check_field("report_saturation", 32'(want.sat), 32'(got.sat));
                    check_field("report_value", 32'(want.val), 32'(got.val));
                end
            end
            if (s_tvalid && s_tready) begin
                predict_lamp_command(s_tuser, s_tdata[0], s_tdata[9:1], s_tdata[16:10],
                                     s_tdata[23:17]);
            end
        end
        pending <= expected_drives.size();
        errors <= err_cnt;
        results <= res_cnt;
    end

endmodule

// ===== verif/hsv_lamp_pwm_controller_unit_test.sv =====
// Testbench top for the HSV lamp PWM controller: clock, reset, request stimulus and verdict.
`timescale 1ns / 1ps

module hsv_lamp_pwm_controller_unit_test;
    import hlpc_pkg::*;

    localparam int HOLD_CYCLES      = 300;
    localparam int QUIET_LIMIT      = 5000;
    localparam int RANDOM_PER_PHASE = 600;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tready = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [M_TUSER_W-1:0] m_tuser;

    int          pending;
    int          errors;
    int          results;
    int unsigned tx_idle_pct = 33;
    int unsigned rx_idle_pct = 53;
    logic        hold_req    = 1'b0;
    logic        hold_ack    = 1'b0;
    int          op_count[4];
    int          quiet_cycles = 0;

    hsv_lamp_pwm_controller_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    hlpc_drive_checker u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .pending  (pending),
        .errors   (errors),
        .results  (results)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("hsv_lamp_pwm_controller_unit_test: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result side: random stalls, plus one long hold on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req != hold_ack) begin
                hold_ack = hold_req;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    task automatic send_command(input logic [OP_W-1:0] op, input logic pwr,
                                input logic [HUE_W-1:0] hue,
                                input logic [PCT_W-1:0] sat,
                                input logic [PCT_W-1:0] val);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {val, sat, hue, pwr};
        do @(posedge aclk); while (!s_tready);
        op_count[op]++;
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (10) @(posedge aclk);
    endtask

    function automatic logic [PCT_W-1:0] rand_pct();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 80) return PCT_W'($urandom_range(100));
        if (pick < 90) return PCT_W'($urandom_range(127, 101));
        return $urandom_range(1) ? PCT_FULL : '0;
    endfunction

    task automatic send_random_command();
        logic [OP_W-1:0]  op;
        logic [HUE_W-1:0] hue;
        int unsigned      pick;
        pick = $urandom_range(99);
        if (pick < 45) op = OP_SET_COLOR;
        else if (pick < 65) op = OP_SET_BRIGHT;
        else if (pick < 82) op = OP_SET_POWER;
        else op = OP_WAKE;
        pick = $urandom_range(99);
        if (pick < 70) hue = HUE_W'($urandom_range(359));
        else if (pick < 85) hue = HUE_W'($urandom_range(511, 360));
        else hue = HUE_W'(60 * $urandom_range(5) + ($urandom_range(1) ? 59 : 0));
        send_command(op, $urandom_range(99) < 70, hue, rand_pct(), rand_pct());
    endtask

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // wake while off after reset, power with the cleared color
        send_command(OP_WAKE, 1'b0, '0, '0, '0);
        send_command(OP_SET_POWER, 1'b1, '0, '0, '0);
        send_command(OP_SET_POWER, 1'b0, '0, '0, '0);
        send_command(OP_WAKE, 1'b0, '0, '0, '0);
        for (int k = 0; k < 6; k++) begin
            send_command(OP_SET_COLOR, 1'b0, HUE_W'(60 * k), PCT_FULL, PCT_FULL);
        end
        send_command(OP_SET_COLOR, 1'b0, 9'd359, PCT_FULL, PCT_FULL);
        send_command(OP_SET_COLOR, 1'b0, HUE_WRAP, 7'd50, PCT_FULL);
        send_command(OP_SET_COLOR, 1'b1, 9'd511, 7'd127, 7'd127);
        send_command(OP_SET_COLOR, 1'b0, 9'd30, '0, PCT_FULL);
        send_command(OP_SET_COLOR, 1'b0, 9'd90, 7'd101, '0);
        send_command(OP_SET_BRIGHT, 1'b0, '0, '0, 7'd127);
        send_command(OP_SET_BRIGHT, 1'b0, '0, '0, '0);
        send_command(OP_SET_BRIGHT, 1'b0, '0, '0, 7'd55);
        send_command(OP_WAKE, 1'b0, '0, '0, '0);
        send_command(OP_SET_POWER, 1'b0, '1, '1, '1);
        send_command(OP_WAKE, 1'b1, '1, '1, '1);
        send_command(OP_SET_BRIGHT, 1'b0, '0, '0, 7'd80);
        send_command(OP_SET_POWER, 1'b1, '0, '0, '0);
        send_command(OP_SET_COLOR, 1'b1, 9'd200, 7'd37, 7'd73);
        send_command(OP_WAKE, 1'b0, '0, '0, '0);
        drain_results();

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 53 : 0;
            rx_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 33 : 0;
            for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
                if (phase == 0 && i == 200) hold_req <= ~hold_req;
                if (i == 300) drain_results();
                send_random_command();
            end
            drain_results();
        end

        repeat (20) @(posedge aclk);
        $display("covered %0d requests: %0d power, %0d color, %0d brightness, %0d wake-up",
                 op_count[OP_SET_POWER] + op_count[OP_SET_COLOR] + op_count[OP_SET_BRIGHT]
                 + op_count[OP_WAKE], op_count[OP_SET_POWER], op_count[OP_SET_COLOR],
                 op_count[OP_SET_BRIGHT], op_count[OP_WAKE]);
        $display("%0d results checked under mixed, swapped and no stalls, one %0d-cycle hold",
                 results, HOLD_CYCLES);
        if (errors == 0) begin
            $display("hsv_lamp_pwm_controller_unit_test: done, clean");
        end else begin
            $display("hsv_lamp_pwm_controller_unit_test: done, errors");
        end
        $finish;
    end

endmodule
